FILE: rtl/lwm_pkg.sv
// lwm_pkg: shared types and sizes for the lookback window maximum block
package lwm_pkg;

   localparam int QUEUE_DEPTH = 1024;
   localparam int VALUE_W     = 31;
   localparam int DAY_W       = 32;

   typedef struct packed {
      logic [VALUE_W-1:0] sample_value;
      logic [DAY_W-1:0]   lookback_days;
   } lwm_req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] window_max;
      logic               window_empty;
      logic               overflow;
   } lwm_rsp_type;

   typedef struct packed {
      logic               valid;
      logic [DAY_W-1:0]   day;
      logic [VALUE_W-1:0] value;
   } lwm_entry_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic               drop;
      logic               commit;
      logic [DAY_W-1:0]   day;
      logic [VALUE_W-1:0] value;
   } lwm_ctrl_type;

   // what the chain reports back about its front and tail
   typedef struct packed {
      lwm_entry_type front;
      logic          full;
   } lwm_status_type;

endpackage

FILE: rtl/lookback_window_max.sv
// lookback_window_max: sliding window maximum over earlier days, top level
// Keeps up to QUEUE_DEPTH (1024) entries of a monotonic deque in a row of cells, front in
// cell 0. An accepted word is first latched, then each stale front entry that falls out of
// the window is dropped (the chain shifts one slot per cycle), then a commit reads the
// front, evicts smaller tail entries and appends the new sample. Every entry is dropped at
// most once. The commit waits while the output register still holds an untaken result.
// The result sits in an output register and the next word is accepted while it waits.
// Results come out in order, one per word.
module lookback_window_max (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lwm_pkg::lwm_req_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lwm_pkg::lwm_rsp_type rsp_word
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_DROP = 1'b1;

   logic                        state_ff;
   logic                        state_in;
   logic [lwm_pkg::DAY_W-1:0]   day_counter_ff;
   logic [lwm_pkg::DAY_W-1:0]   day_counter_in;
   logic [lwm_pkg::DAY_W-1:0]   thresh_ff;
   logic [lwm_pkg::DAY_W-1:0]   thresh_in;
   logic [lwm_pkg::VALUE_W-1:0] sample_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   lwm_pkg::lwm_rsp_type        rsp_word_ff;
   lwm_pkg::lwm_rsp_type        rsp_word_in;

   lwm_pkg::lwm_ctrl_type       ctrl;
   lwm_pkg::lwm_status_type     status;
   logic                        accept;
   logic                        stale;
   logic                        commit;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // oldest day still inside today's window
   assign thresh_in = (req_word.lookback_days >= day_counter_ff) ? '0
                      : day_counter_ff - req_word.lookback_days;

   assign stale  = (state_ff == S_DROP) && status.front.valid
                   && (status.front.day < thresh_ff);
   assign commit = (state_ff == S_DROP) && !stale && (!rsp_valid_ff || rsp_ready);

   assign ctrl.drop   = stale;
   assign ctrl.commit = commit;
   assign ctrl.day    = day_counter_ff;
   assign ctrl.value  = sample_ff;

   lwm_chain u_chain (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .status (status)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DROP;
            end
         end
         S_DROP: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      day_counter_in = day_counter_ff;
      if (commit && (day_counter_ff != '1)) begin
         day_counter_in = day_counter_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (commit) begin
         rsp_valid_in             = 1'b1;
         rsp_word_in.window_max   = status.front.valid ? status.front.value : '0;
         rsp_word_in.window_empty = !status.front.valid;
         rsp_word_in.overflow     = status.full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         day_counter_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         day_counter_ff <= day_counter_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      if (accept) begin
         thresh_ff <= thresh_in;
         sample_ff <= req_word.sample_value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTHESIS
   a_ovf_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.overflow |-> !rsp_word_ff.window_empty)
      else $error("overflow reported with an empty window");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.window_empty |-> (rsp_word_ff.window_max == '0))
      else $error("empty window carries a nonzero maximum");

   a_full_has_front: assert property (@(posedge clock) disable iff (reset)
      status.full |-> status.front.valid)
      else $error("chain full without a valid front");

   a_day_hold: assert property (@(posedge clock) disable iff (reset)
      !commit |=> $stable(day_counter_ff))
      else $error("day counter moved without a commit");

   a_commit_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("commit did not load the response register");
`endif

endmodule

FILE: rtl/lwm_cell.sv
// lwm_cell: one deque slot; shifts toward the front on a drop or a full commit, evicts or fills on a commit
module lwm_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  lwm_pkg::lwm_ctrl_type  ctrl,
   input  logic                   full,
   input  logic                   left_kept,
   input  lwm_pkg::lwm_entry_type right_entry,
   output lwm_pkg::lwm_entry_type entry_out,
   output logic                   kept_out
);

   logic                        valid_ff;
   logic                        valid_in;
   logic [lwm_pkg::DAY_W-1:0]   day_ff;
   logic [lwm_pkg::DAY_W-1:0]   day_in;
   logic [lwm_pkg::VALUE_W-1:0] value_ff;
   logic [lwm_pkg::VALUE_W-1:0] value_in;

   // survives eviction when the new value is not larger
   assign kept_out = valid_ff && !(value_ff < ctrl.value);

   assign entry_out.valid = valid_ff;
   assign entry_out.day   = day_ff;
   assign entry_out.value = value_ff;

   always_comb begin
      valid_in = valid_ff;
      day_in   = day_ff;
      value_in = value_ff;
      if (ctrl.drop || (ctrl.commit && full)) begin
         valid_in = right_entry.valid;
         day_in   = right_entry.day;
         value_in = right_entry.value;
      end else if (ctrl.commit) begin
         if (kept_out) begin
            valid_in = 1'b1;
         end else if (left_kept) begin
            // first free slot after the kept run takes the new word
            valid_in = 1'b1;
            day_in   = ctrl.day;
            value_in = ctrl.value;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      day_ff   <= day_in;
      value_ff <= value_in;
   end

endmodule

FILE: rtl/lwm_chain.sv
// lwm_chain: row of deque cells, front at cell 0, newest entries toward the far end
module lwm_chain (
   input  logic                   clock,
   input  logic                   reset,
   input  lwm_pkg::lwm_ctrl_type  ctrl,
   output lwm_pkg::lwm_status_type status
);

   lwm_pkg::lwm_entry_type entries [lwm_pkg::QUEUE_DEPTH];
   lwm_pkg::lwm_entry_type tail_feed;
   logic [lwm_pkg::QUEUE_DEPTH-1:0] kept;
   logic                            full;

   // all slots survive eviction only when the deque is completely full
   assign full = kept[lwm_pkg::QUEUE_DEPTH-1];

   // past the last cell: empty on a drop, the new word on a full commit
   assign tail_feed.valid = ctrl.commit;
   assign tail_feed.day   = ctrl.day;
   assign tail_feed.value = ctrl.value;

   for (genvar i = 0; i < lwm_pkg::QUEUE_DEPTH; i++) begin : g_cell
      lwm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .full        (full),
         .left_kept   ((i == 0) ? 1'b1 : kept[(i == 0) ? 0 : i-1]),
         .right_entry ((i == lwm_pkg::QUEUE_DEPTH-1) ? tail_feed
                       : entries[(i == lwm_pkg::QUEUE_DEPTH-1) ? i : i+1]),
         .entry_out   (entries[i]),
         .kept_out    (kept[i])
      );
   end

   assign status.front = entries[0];
   assign status.full  = full;

endmodule
